// File: rtl/mmg_pkg.sv
`timescale 1ns / 1ps

package mmg_pkg;

    // action codes
    localparam logic [3:0] ACT_COMMAND       = 4'd0;
    localparam logic [3:0] ACT_SESS_START    = 4'd1;
    localparam logic [3:0] ACT_SESS_DONE     = 4'd2;
    localparam logic [3:0] ACT_SESS_ABORT    = 4'd3;
    localparam logic [3:0] ACT_CUST_GONE     = 4'd4;
    localparam logic [3:0] ACT_SELFCHK_DONE  = 4'd5;
    localparam logic [3:0] ACT_CRITICAL      = 4'd6;
    localparam logic [3:0] ACT_BLOCKING      = 4'd7;
    localparam logic [3:0] ACT_ESTOP         = 4'd8;
    localparam logic [3:0] ACT_RECOVERY_DONE = 4'd9;
    localparam logic [3:0] ACT_HOME_DONE     = 4'd10;
    localparam logic [3:0] ACT_INIT          = 4'd11;

    // command codes
    localparam logic [3:0] CMD_START_WASH = 4'd1;
    localparam logic [3:0] CMD_STOP_WASH  = 4'd2;
    localparam logic [3:0] CMD_STOP_OP    = 4'd3;
    localparam logic [3:0] CMD_RESUME_OP  = 4'd4;
    localparam logic [3:0] CMD_MANUAL     = 4'd5;
    localparam logic [3:0] CMD_SELFCHECK  = 4'd6;
    localparam logic [3:0] CMD_RECOVER    = 4'd7;
    localparam logic [3:0] CMD_STOP_ALL   = 4'd8;

    // mode codes as seen on the result
    localparam logic [2:0] MD_INIT         = 3'd0;
    localparam logic [2:0] MD_STOPPED      = 3'd1;
    localparam logic [2:0] MD_IDLE         = 3'd2;
    localparam logic [2:0] MD_WASHING      = 3'd3;
    localparam logic [2:0] MD_ABORT_HOMING = 3'd4;
    localparam logic [2:0] MD_DONE         = 3'd5;
    localparam logic [2:0] MD_SELFCHECK    = 3'd6;
    localparam logic [2:0] MD_RECOVERING   = 3'd7;

    // reject reasons
    localparam logic [2:0] RJ_NONE       = 3'd0;
    localparam logic [2:0] RJ_UNKNOWN    = 3'd1;
    localparam logic [2:0] RJ_WRONG_MODE = 3'd2;
    localparam logic [2:0] RJ_ESTOP      = 3'd3;
    localparam logic [2:0] RJ_SERVICE    = 3'd4;
    localparam logic [2:0] RJ_NOT_READY  = 3'd5;

    // effects
    localparam logic [2:0] EFF_NONE       = 3'd0;
    localparam logic [2:0] EFF_START_WASH = 3'd1;
    localparam logic [2:0] EFF_STOP_WASH  = 3'd2;
    localparam logic [2:0] EFF_SELFCHECK  = 3'd3;
    localparam logic [2:0] EFF_MANUAL     = 3'd4;
    localparam logic [2:0] EFF_STOP_OUT   = 3'd5;
    localparam logic [2:0] EFF_STOP_ABORT = 3'd6;

    // permission entries
    localparam logic [1:0] PERM_NO   = 2'd0;
    localparam logic [1:0] PERM_YES  = 2'd1;
    localparam logic [1:0] PERM_COND = 2'd2;

    typedef enum logic [7:0] {
        MODE_OH_INIT         = 8'b0000_0001,
        MODE_OH_STOPPED      = 8'b0000_0010,
        MODE_OH_IDLE         = 8'b0000_0100,
        MODE_OH_WASHING      = 8'b0000_1000,
        MODE_OH_ABORT_HOMING = 8'b0001_0000,
        MODE_OH_DONE         = 8'b0010_0000,
        MODE_OH_SELFCHECK    = 8'b0100_0000,
        MODE_OH_RECOVERING   = 8'b1000_0000
    } t_mode_oh;

    typedef struct packed {
        logic [3:0] action;
        logic [3:0] command;
        logic       blocking_alarm_active;
        logic       entry_ready;
        logic       event_flag;
    } t_item;

    typedef struct packed {
        logic       verdict;
        logic [2:0] reject_reason;
        logic [2:0] effect;
        logic [2:0] mode;
        logic [2:0] prev_mode;
        logic       mode_changed;
        logic       estop_latched;
        logic       service_on;
        logic       stopping;
        logic       recovery_request;
        logic       home_request;
        logic       context_sync;
    } t_result;

    // machine context handed between the state registers and the decision logic
    typedef struct packed {
        logic [2:0] mode;
        logic       estop;
        logic       service;
    } t_ctx;

    // 2-bit entry per mode, mode m at bits [2m+1:2m]
    function automatic logic [1:0] perm_lookup(input logic [3:0] cmd, input logic [2:0] mode);
        logic [15:0] row;
        unique case (cmd)
            CMD_START_WASH: row = 16'h0020;
            CMD_STOP_WASH:  row = 16'h0040;
            CMD_STOP_OP:    row = 16'h0414;
            CMD_RESUME_OP:  row = 16'h5554;
            CMD_MANUAL:     row = 16'h0008;
            CMD_SELFCHECK:  row = 16'h0008;
            CMD_RECOVER:    row = 16'h0018;
            CMD_STOP_ALL:   row = 16'h5554;
            default:        row = 16'h0000;
        endcase
        return row[{mode, 1'b0} +: 2];
    endfunction

    function automatic logic [2:0] grant_effect(input logic [3:0] cmd);
        logic [2:0] eff;
        unique case (cmd)
            CMD_START_WASH: eff = EFF_START_WASH;
            CMD_STOP_WASH:  eff = EFF_STOP_WASH;
            CMD_MANUAL:     eff = EFF_MANUAL;
            CMD_SELFCHECK:  eff = EFF_SELFCHECK;
            default:        eff = EFF_NONE;
        endcase
        return eff;
    endfunction

    function automatic t_mode_oh mode_to_oh(input logic [2:0] mode);
        return t_mode_oh'(8'b0000_0001 << mode);
    endfunction

    function automatic logic [2:0] oh_to_mode(input t_mode_oh oh);
        logic [2:0] m;
        m = 3'd0;
        for (int k = 0; k < 8; k++) begin
            if (oh[k]) begin
                m = m | 3'(k);
            end
        end
        return m;
    endfunction

endpackage

// File: rtl/mmg_decide.sv
`timescale 1ns / 1ps

module mmg_decide import mmg_pkg::*; (
    input  t_item   i_item,
    input  t_ctx    i_ctx,
    output t_result o_res,
    output t_ctx    o_ctx
);

    logic [2:0] prev;
    logic [2:0] reason;
    logic [1:0] perm;
    logic       known;
    logic [3:0] cmd;
    t_ctx       nxt;
    t_result    res;

    assign prev  = i_ctx.mode;
    assign cmd   = i_item.command;
    assign known = (cmd != 4'd0) && (cmd <= CMD_STOP_ALL);
    assign perm  = perm_lookup(cmd, prev);

    always_comb begin
        priority if (!known) begin
            reason = RJ_UNKNOWN;
        end else if (perm == PERM_NO) begin
            reason = RJ_WRONG_MODE;
        end else if (perm == PERM_COND && i_ctx.estop) begin
            reason = RJ_ESTOP;
        end else if (cmd == CMD_START_WASH && !i_ctx.service) begin
            reason = RJ_SERVICE;
        end else if (cmd == CMD_START_WASH && i_item.blocking_alarm_active) begin
            reason = RJ_WRONG_MODE;
        end else if (cmd == CMD_START_WASH && !i_item.entry_ready) begin
            reason = RJ_NOT_READY;
        end else if (cmd == CMD_RECOVER && !i_ctx.service) begin
            reason = RJ_SERVICE;
        end else if (cmd == CMD_RESUME_OP && i_ctx.service) begin
            reason = RJ_WRONG_MODE;
        end else begin
            reason = RJ_NONE;
        end
    end

    always_comb begin
        nxt = i_ctx;
        res = '0;
        res.verdict = 1'b1;
        unique case (i_item.action)
            ACT_COMMAND: begin
                res.reject_reason = reason;
                if (reason != RJ_NONE) begin
                    res.verdict = 1'b0;
                end else begin
                    res.effect = grant_effect(cmd);
                    unique case (cmd)
                        CMD_SELFCHECK: nxt.mode = MD_SELFCHECK;
                        CMD_RECOVER: begin
                            if (prev == MD_STOPPED) begin
                                nxt.mode             = MD_RECOVERING;
                                res.recovery_request = 1'b1;
                            end
                        end
                        CMD_STOP_OP: begin
                            nxt.service      = 1'b0;
                            nxt.mode         = MD_STOPPED;
                            res.context_sync = 1'b1;
                        end
                        CMD_RESUME_OP: begin
                            nxt.service      = 1'b1;
                            res.context_sync = 1'b1;
                        end
                        CMD_STOP_ALL: begin
                            res.effect = (prev == MD_WASHING) ? EFF_STOP_ABORT : EFF_STOP_OUT;
                            nxt.mode   = MD_STOPPED;
                        end
                        default: ;
                    endcase
                end
            end
            ACT_SESS_START: if (prev == MD_IDLE) nxt.mode = MD_WASHING;
            ACT_SESS_DONE: begin
                if (prev == MD_WASHING) begin
                    nxt.mode = i_item.blocking_alarm_active ? MD_STOPPED : MD_DONE;
                end
            end
            ACT_SESS_ABORT: begin
                if (prev == MD_WASHING) begin
                    nxt.mode         = MD_ABORT_HOMING;
                    res.home_request = 1'b1;
                end
            end
            ACT_CUST_GONE:    if (prev == MD_DONE) nxt.mode = MD_IDLE;
            ACT_SELFCHK_DONE: if (prev == MD_SELFCHECK) nxt.mode = MD_STOPPED;
            ACT_CRITICAL, ACT_BLOCKING: begin
                // alarms do not interrupt a wash, homing or recovery
                if (prev != MD_WASHING && prev != MD_ABORT_HOMING && prev != MD_RECOVERING) begin
                    nxt.mode = MD_STOPPED;
                end
            end
            ACT_ESTOP: begin
                nxt.estop = i_item.event_flag;
                if (i_item.event_flag) begin
                    nxt.mode = MD_STOPPED;
                end else begin
                    res.context_sync = 1'b1;
                end
            end
            ACT_RECOVERY_DONE: begin
                if (prev == MD_RECOVERING) begin
                    nxt.mode = i_item.event_flag ? MD_IDLE : MD_STOPPED;
                end
            end
            ACT_HOME_DONE: if (prev == MD_ABORT_HOMING) nxt.mode = MD_STOPPED;
            ACT_INIT: begin
                nxt.mode    = MD_STOPPED;
                nxt.estop   = 1'b0;
                nxt.service = 1'b1;
            end
            default: ;
        endcase

        res.mode          = nxt.mode;
        res.prev_mode     = prev;
        res.mode_changed  = (nxt.mode != prev);
        res.estop_latched = nxt.estop;
        res.service_on    = nxt.service;
        res.stopping      = (nxt.mode == MD_INIT) || (nxt.mode == MD_STOPPED) ||
                            (nxt.mode == MD_RECOVERING) || (nxt.mode == MD_ABORT_HOMING) ||
                            (nxt.mode == MD_SELFCHECK) || !nxt.service;
    end

    assign o_res = res;
    assign o_ctx = nxt;

endmodule

// File: rtl/machine_mode_guard_fsm_core.sv
`timescale 1ns / 1ps
// Mode guard for the wash machine: eight operating modes, estop latch and
// service-enable flag.
// Input channel (i_in_valid / o_in_stall / i_in): one beat per command or
// event. Output channel (o_out_valid / i_out_stall / o_out): exactly one
// result beat per input beat, in order.
// A beat taken into the input register is judged against the mode registers
// and its result is loaded into the result register that drives o_out.
// Throughput: one beat per cycle while o_in_stall is low; the mode and flag
// registers update in the same edge that loads the result, so the next beat
// always sees the state left by the one before it.
// When the receiver stalls, the result register holds; the input register
// keeps taking one more beat, then o_in_stall rises until the result drains.
// Reset (i_rst_n low, synchronous): both pipeline slots empty, mode init,
// estop clear, service enabled.

module machine_mode_guard_fsm_core import mmg_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_item   i_in,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_out
);

    logic     r_in_valid;
    t_item    r_in;
    logic     r_out_valid;
    t_result  r_out;
    t_mode_oh r_mode;
    logic     r_estop;
    logic     r_service;

    logic     out_free;
    logic     move;
    logic     in_take;
    t_ctx     cur_ctx;
    t_ctx     n_ctx;
    t_result  n_out;

    assign out_free = !r_out_valid || !i_out_stall;
    assign move     = r_in_valid && out_free;
    assign in_take  = i_in_valid && !o_in_stall;

    assign o_in_stall  = r_in_valid && !out_free;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign cur_ctx.mode    = oh_to_mode(r_mode);
    assign cur_ctx.estop   = r_estop;
    assign cur_ctx.service = r_service;

    mmg_decide u_decide (
        .i_item (r_in),
        .i_ctx  (cur_ctx),
        .o_res  (n_out),
        .o_ctx  (n_ctx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_OH_INIT;
            r_estop     <= 1'b0;
            r_service   <= 1'b1;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
                r_mode      <= mode_to_oh(n_ctx.mode);
                r_estop     <= n_ctx.estop;
                r_service   <= n_ctx.service;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in;
        end
        if (move) begin
            r_out <= n_out;
        end
    end

    // the mode register stays one-hot
    a_mode_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_mode))
        else $error("mode register not one-hot");

    // a freshly loaded result reports the mode now held in the state registers
    a_result_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> (r_out.mode == oh_to_mode(r_mode)) && (r_out.estop_latched == r_estop)
                 && (r_out.service_on == r_service))
        else $error("result disagrees with state registers");

    // a denied command has no effect and leaves the mode alone
    a_denied_no_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.verdict) |->
            (r_out.effect == EFF_NONE) && !r_out.mode_changed && (r_out.reject_reason != RJ_NONE))
        else $error("denied command changed state");

    // state only moves when a beat passes into the result register
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !move |=> $stable(r_mode) && $stable(r_estop) && $stable(r_service))
        else $error("state changed without a beat");

endmodule

// File: verif/tb_machine_mode_guard_fsm_core.sv
`timescale 1ns / 1ps

module tb_machine_mode_guard_fsm_core;
    import mmg_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 8;

    // codes outside the defined action and command sets
    localparam logic [3:0] ACT_UNUSED_TOP   = 4'd15;
    localparam logic [3:0] CMD_UNKNOWN_ZERO = 4'd0;
    localparam logic [3:0] CMD_UNKNOWN_TOP  = 4'd15;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_in_valid = 1'b0;
    logic    o_in_stall;
    t_item   i_in = '0;
    logic    o_out_valid;
    logic    i_out_stall = 1'b0;
    t_result o_out;

    machine_mode_guard_fsm_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // predicted machine context
    logic [2:0] guard_mode = MD_INIT;
    logic       guard_estop = 1'b0;
    logic       guard_service = 1'b1;

    t_result guard_results_due[$];
    int      mismatches = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      hold_len = 0;
    int      cycle_count = 0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic [1:0] permission(input logic [3:0] cmd, input logic [2:0] md);
        logic [1:0] p;
        p = PERM_NO;
        case (cmd)
            CMD_START_WASH: if (md == MD_IDLE) p = PERM_COND;
            CMD_STOP_WASH:  if (md == MD_WASHING) p = PERM_YES;
            CMD_STOP_OP: begin
                if (md == MD_STOPPED || md == MD_IDLE || md == MD_DONE) p = PERM_YES;
            end
            CMD_RESUME_OP, CMD_STOP_ALL: if (md != MD_INIT) p = PERM_YES;
            CMD_MANUAL, CMD_SELFCHECK: if (md == MD_STOPPED) p = PERM_COND;
            CMD_RECOVER: begin
                if (md == MD_STOPPED) p = PERM_COND;
                else if (md == MD_IDLE) p = PERM_YES;
            end
            default: p = PERM_NO;
        endcase
        return p;
    endfunction

    function automatic logic [2:0] judge_command(input t_item it);
        logic [1:0] p;
        if (it.command < CMD_START_WASH || it.command > CMD_STOP_ALL) return RJ_UNKNOWN;
        p = permission(it.command, guard_mode);
        if (p == PERM_NO) return RJ_WRONG_MODE;
        if (p == PERM_COND && guard_estop) return RJ_ESTOP;
        if (it.command == CMD_START_WASH) begin
            if (!guard_service) return RJ_SERVICE;
            if (it.blocking_alarm_active) return RJ_WRONG_MODE;
            if (!it.entry_ready) return RJ_NOT_READY;
        end
        if (it.command == CMD_RECOVER && !guard_service) return RJ_SERVICE;
        if (it.command == CMD_RESUME_OP && guard_service) return RJ_WRONG_MODE;
        return RJ_NONE;
    endfunction

    // advances the predicted context by one beat and returns its result
    function automatic t_result predict_guard_result(input t_item it);
        t_result    r;
        logic [2:0] prev;
        prev = guard_mode;
        r = '0;
        r.verdict = 1'b1;
        r.prev_mode = prev;
        case (it.action)
            ACT_COMMAND: begin
                r.reject_reason = judge_command(it);
                if (r.reject_reason != RJ_NONE) begin
                    r.verdict = 1'b0;
                end else begin
                    case (it.command)
                        CMD_START_WASH: r.effect = EFF_START_WASH;
                        CMD_STOP_WASH:  r.effect = EFF_STOP_WASH;
                        CMD_MANUAL:     r.effect = EFF_MANUAL;
                        CMD_SELFCHECK: begin
                            r.effect = EFF_SELFCHECK;
                            guard_mode = MD_SELFCHECK;
                        end
                        CMD_RECOVER: begin
                            // recover while idle is granted but does nothing
                            if (prev == MD_STOPPED) begin
                                guard_mode = MD_RECOVERING;
                                r.recovery_request = 1'b1;
                            end
                        end
                        CMD_STOP_OP: begin
                            guard_service = 1'b0;
                            r.context_sync = 1'b1;
                            guard_mode = MD_STOPPED;
                        end
                        CMD_RESUME_OP: begin
                            guard_service = 1'b1;
                            r.context_sync = 1'b1;
                        end
                        CMD_STOP_ALL: begin
                            r.effect = (prev == MD_WASHING) ? EFF_STOP_ABORT : EFF_STOP_OUT;
                            guard_mode = MD_STOPPED;
                        end
                        default: ;
                    endcase
                end
            end
            ACT_SESS_START: if (prev == MD_IDLE) guard_mode = MD_WASHING;
            ACT_SESS_DONE: begin
                if (prev == MD_WASHING)
                    guard_mode = it.blocking_alarm_active ? MD_STOPPED : MD_DONE;
            end
            ACT_SESS_ABORT: begin
                if (prev == MD_WASHING) begin
                    guard_mode = MD_ABORT_HOMING;
                    r.home_request = 1'b1;
                end
            end
            ACT_CUST_GONE:    if (prev == MD_DONE) guard_mode = MD_IDLE;
            ACT_SELFCHK_DONE: if (prev == MD_SELFCHECK) guard_mode = MD_STOPPED;
            ACT_CRITICAL, ACT_BLOCKING: begin
                // alarms leave an active motion sequence to finish on its own
                if (prev != MD_WASHING && prev != MD_ABORT_HOMING && prev != MD_RECOVERING)
                    guard_mode = MD_STOPPED;
            end
            ACT_ESTOP: begin
                guard_estop = it.event_flag;
                if (it.event_flag) guard_mode = MD_STOPPED;
                else r.context_sync = 1'b1;
            end
            ACT_RECOVERY_DONE: begin
                if (prev == MD_RECOVERING)
                    guard_mode = it.event_flag ? MD_IDLE : MD_STOPPED;
            end
            ACT_HOME_DONE: if (prev == MD_ABORT_HOMING) guard_mode = MD_STOPPED;
            ACT_INIT: begin
                guard_mode = MD_STOPPED;
                guard_estop = 1'b0;
                guard_service = 1'b1;
            end
            default: ;
        endcase
        r.mode = guard_mode;
        r.mode_changed = (guard_mode != prev);
        r.estop_latched = guard_estop;
        r.service_on = guard_service;
        r.stopping = guard_mode == MD_INIT || guard_mode == MD_STOPPED ||
                     guard_mode == MD_RECOVERING || guard_mode == MD_ABORT_HOMING ||
                     guard_mode == MD_SELFCHECK || !guard_service;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    function automatic t_item beat_of(input logic [3:0] act, input logic [3:0] cmd,
                                      input logic blk = 1'b0, input logic rdy = 1'b1,
                                      input logic flg = 1'b0);
        t_item it;
        it.action = act;
        it.command = cmd;
        it.blocking_alarm_active = blk;
        it.entry_ready = rdy;
        it.event_flag = flg;
        return it;
    endfunction

    // valid stays high between back-to-back beats; only an idle gap lowers it
    task automatic send_beat(input t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (o_in_stall);
        guard_results_due.push_back(predict_guard_result(it));
    endtask

    // mostly legal sequences for the current mode, the rest random noise
    function automatic t_item pick_beat();
        t_item      it;
        logic [3:0] stopped_cmds[6];
        logic [3:0] wash_acts[4];
        stopped_cmds = '{CMD_RECOVER, CMD_RECOVER, CMD_SELFCHECK, CMD_MANUAL,
                         CMD_STOP_OP, CMD_STOP_ALL};
        wash_acts = '{ACT_SESS_DONE, ACT_SESS_ABORT, ACT_SESS_DONE, ACT_COMMAND};
        it.action = 4'($urandom_range(15));
        it.command = 4'($urandom_range(15));
        it.blocking_alarm_active = 1'($urandom_range(1));
        it.entry_ready = 1'($urandom_range(1));
        it.event_flag = 1'($urandom_range(1));
        if ($urandom_range(99) < 20) return it;

        it.blocking_alarm_active = ($urandom_range(7) == 0);
        it.entry_ready = ($urandom_range(7) != 0);
        it.event_flag = ($urandom_range(5) != 0);
        if (guard_estop && $urandom_range(99) < 70) begin
            it.action = ACT_ESTOP;
            it.event_flag = 1'b0;
        end else if (!guard_service && $urandom_range(99) < 60) begin
            it.action = ACT_COMMAND;
            it.command = CMD_RESUME_OP;
        end else if ($urandom_range(99) < 5) begin
            it.action = 4'($urandom_range(ACT_CRITICAL, ACT_ESTOP));
        end else begin
            case (guard_mode)
                MD_INIT:         it.action = ACT_INIT;
                MD_STOPPED: begin
                    it.action = ACT_COMMAND;
                    it.command = stopped_cmds[3'($urandom_range(5))];
                end
                MD_IDLE: begin
                    it.action = $urandom_range(1) ? ACT_COMMAND : ACT_SESS_START;
                    it.command = $urandom_range(3) ? CMD_START_WASH : CMD_STOP_OP;
                end
                MD_WASHING: begin
                    it.action = wash_acts[2'($urandom_range(3))];
                    it.command = $urandom_range(1) ? CMD_STOP_WASH : CMD_STOP_ALL;
                end
                MD_ABORT_HOMING: it.action = ACT_HOME_DONE;
                MD_DONE: begin
                    it.action = $urandom_range(3) ? ACT_CUST_GONE : ACT_COMMAND;
                    it.command = CMD_STOP_OP;
                end
                MD_SELFCHECK:    it.action = ACT_SELFCHK_DONE;
                default:         it.action = ACT_RECOVERY_DONE;
            endcase
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // output side: checker and stall driver
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [2:0] want,
                                 input logic [2:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    task automatic check_beat(input t_result got);
        t_result want;
        if (guard_results_due.size() == 0) begin
            mismatches++;
            $display("%0t: result with nothing expected, expected none actual %h", $time, got);
        end else begin
            want = guard_results_due.pop_front();
            compare_field("verdict", 3'(want.verdict), 3'(got.verdict));
            compare_field("reject_reason", want.reject_reason, got.reject_reason);
            compare_field("effect", want.effect, got.effect);
            compare_field("mode", want.mode, got.mode);
            compare_field("prev_mode", want.prev_mode, got.prev_mode);
            compare_field("mode_changed", 3'(want.mode_changed), 3'(got.mode_changed));
            compare_field("estop_latched", 3'(want.estop_latched), 3'(got.estop_latched));
            compare_field("service_on", 3'(want.service_on), 3'(got.service_on));
            compare_field("stopping", 3'(want.stopping), 3'(got.stopping));
            compare_field("recovery_request", 3'(want.recovery_request),
                          3'(got.recovery_request));
            compare_field("home_request", 3'(want.home_request), 3'(got.home_request));
            compare_field("context_sync", 3'(want.context_sync), 3'(got.context_sync));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_beat(o_out);
        i_out_stall <= (hold_len > 1) || ($urandom_range(99) < recv_idle_pct);
    end

    // long receiver hold-off, counted down here
    always @(posedge i_clk) begin
        if (hold_len > 0) hold_len <= hold_len - 1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        send_beat(beat_of(ACT_COMMAND, CMD_STOP_ALL));             // nothing allowed in init
        send_beat(beat_of(ACT_COMMAND, CMD_UNKNOWN_ZERO, 1'b0, 1'b0, 1'b0));
        send_beat(beat_of(ACT_COMMAND, CMD_UNKNOWN_TOP, 1'b1, 1'b1, 1'b1));
        send_beat(beat_of(ACT_INIT, CMD_START_WASH));
        send_beat(beat_of(ACT_COMMAND, CMD_SELFCHECK));
        send_beat(beat_of(ACT_SELFCHK_DONE, CMD_START_WASH));
        send_beat(beat_of(ACT_COMMAND, CMD_MANUAL));
        send_beat(beat_of(ACT_ESTOP, CMD_START_WASH, 1'b0, 1'b1, 1'b1));
        send_beat(beat_of(ACT_COMMAND, CMD_MANUAL));               // refused under estop
        send_beat(beat_of(ACT_COMMAND, CMD_STOP_ALL));
        send_beat(beat_of(ACT_ESTOP, CMD_START_WASH, 1'b0, 1'b1, 1'b0));
        send_beat(beat_of(ACT_COMMAND, CMD_STOP_OP));
        send_beat(beat_of(ACT_COMMAND, CMD_RECOVER));              // service off
        send_beat(beat_of(ACT_COMMAND, CMD_RESUME_OP));
        send_beat(beat_of(ACT_COMMAND, CMD_RESUME_OP));            // service already on
        send_beat(beat_of(ACT_COMMAND, CMD_RECOVER));
        send_beat(beat_of(ACT_RECOVERY_DONE, CMD_START_WASH, 1'b0, 1'b1, 1'b1));
        send_beat(beat_of(ACT_COMMAND, CMD_RECOVER));              // idle: no-op grant
        send_beat(beat_of(ACT_COMMAND, CMD_START_WASH, 1'b1, 1'b1));
        send_beat(beat_of(ACT_COMMAND, CMD_START_WASH, 1'b0, 1'b0));
        send_beat(beat_of(ACT_COMMAND, CMD_START_WASH));
        send_beat(beat_of(ACT_SESS_START, CMD_START_WASH));
        send_beat(beat_of(ACT_CRITICAL, CMD_START_WASH));          // ignored while washing
        send_beat(beat_of(ACT_SESS_ABORT, CMD_START_WASH));
        send_beat(beat_of(ACT_HOME_DONE, CMD_START_WASH));
        send_beat(beat_of(ACT_UNUSED_TOP, CMD_UNKNOWN_TOP, 1'b1, 1'b1, 1'b1));
        send_beat(beat_of(ACT_BLOCKING, CMD_START_WASH));
    endtask

    task automatic test_random(input int count, input int snd_pct, input int rcv_pct);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        repeat (count) send_beat(pick_beat());
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (hold_len != 0) @(posedge i_clk);
        hold_len <= 150;
        repeat (40) send_beat(pick_beat());
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 30;
        recv_idle_pct = 79;
        test_directed();
        test_random(230, 30, 79);
        test_random(230, 79, 30);
        test_backpressure();
        test_random(230, 0, 0);
        i_in_valid <= 1'b0;
        while (guard_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/mmg_pkg.sv
rtl/mmg_decide.sv
rtl/machine_mode_guard_fsm_core.sv
verif/tb_machine_mode_guard_fsm_core.sv
